FILE: design/acm_pkg.sv
// Shared types, opcodes and the microcode ROM of the accumulator machine.
package acm_pkg;

    // Default program and data memory depth
    localparam int MEM_DEPTH_DEF = 128;
    // Span of the 7-bit address fields in a word
    localparam int ADDR_SPAN     = 128;
    localparam int DATA_W        = 32;
    localparam int OPC_W         = 4;
    localparam int FLD_W         = 7;
    localparam int PWORD_W       = OPC_W + FLD_W;
    localparam int UA_W          = 5;

    // Instruction opcodes
    localparam logic [OPC_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'd2;
    localparam logic [OPC_W-1:0] OP_STORE = 4'd3;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd4;
    localparam logic [OPC_W-1:0] OP_IN    = 4'd5;
    localparam logic [OPC_W-1:0] OP_OUT   = 4'd6;
    localparam logic [OPC_W-1:0] OP_HALT  = 4'd7;
    localparam logic [OPC_W-1:0] OP_JUMP  = 4'd8;
    localparam logic [OPC_W-1:0] OP_SKIPZ = 4'd9;

    // Micro-program addresses
    typedef enum logic [UA_W-1:0] {
        U_CLEAR  = 5'd0,
        U_IDLE   = 5'd1,
        U_DECODE = 5'd2,
        U_CHECK  = 5'd3,
        U_FETCH  = 5'd4,
        U_LOAD   = 5'd5,
        U_ADD    = 5'd6,
        U_SUB    = 5'd7,
        U_STORE  = 5'd8,
        U_IN     = 5'd9,
        U_OUT    = 5'd10,
        U_HALT   = 5'd11,
        U_JUMP   = 5'd12,
        U_SKIPZ  = 5'd13,
        U_FAULT  = 5'd14,
        U_PWRITE = 5'd15,
        U_EMIT   = 5'd16
    } t_uaddr;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        JC_NEXT,      // fall through
        JC_GOTO,      // unconditional jump to target
        JC_WAIT_CLR,  // hold while memory clear runs, then fall through
        JC_WAIT_ACC,  // hold until a word is accepted, then fall through
        JC_IF_WRITE,  // program write -> target
        JC_IF_STOP,   // machine stopped -> target
        JC_DISPATCH,  // jump by fetched opcode
        JC_WAIT_OUT   // hold while result register is full and stalled, then target
    } t_jcond;

    // Accumulator update select
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_MEM,
        ACC_ADD,
        ACC_SUB,
        ACC_IN
    } t_accop;

    // One control word
    typedef struct packed {
        logic   in_rdy;
        logic   clr;
        logic   prog_wr;
        logic   prog_rd;
        logic   pc_inc;
        logic   data_rd;
        logic   data_wr;
        t_accop acc_op;
        logic   set_show;
        logic   set_halt;
        logic   set_fault;
        logic   pc_jump;
        logic   pc_skipz;
        logic   out_load;
        t_jcond jc;
        t_uaddr target;
    } t_uctl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic             in_acc;
        logic             is_write;
        logic             stopped;
        logic             clr_busy;
        logic             out_busy;
        logic [OPC_W-1:0] opcode;
    } t_ustat;

    localparam t_uctl UC_NOP = '{
        in_rdy: 1'b0, clr: 1'b0, prog_wr: 1'b0, prog_rd: 1'b0, pc_inc: 1'b0,
        data_rd: 1'b0, data_wr: 1'b0, acc_op: ACC_HOLD, set_show: 1'b0,
        set_halt: 1'b0, set_fault: 1'b0, pc_jump: 1'b0, pc_skipz: 1'b0,
        out_load: 1'b0, jc: JC_GOTO, target: U_EMIT
    };

    // Microcode ROM
    function automatic t_uctl ucode(input t_uaddr ua);
        t_uctl c;
        c = UC_NOP;
        case (ua)
            U_CLEAR: begin
                c.clr = 1'b1;
                c.jc  = JC_WAIT_CLR;
            end
            U_IDLE: begin
                c.in_rdy = 1'b1;
                c.jc     = JC_WAIT_ACC;
            end
            U_DECODE: begin
                c.jc     = JC_IF_WRITE;
                c.target = U_PWRITE;
            end
            U_CHECK: begin
                c.prog_rd = 1'b1;
                c.jc      = JC_IF_STOP;
                c.target  = U_EMIT;
            end
            U_FETCH: begin
                c.pc_inc  = 1'b1;
                c.data_rd = 1'b1;
                c.jc      = JC_DISPATCH;
            end
            U_LOAD:   c.acc_op    = ACC_MEM;
            U_ADD:    c.acc_op    = ACC_ADD;
            U_SUB:    c.acc_op    = ACC_SUB;
            U_STORE:  c.data_wr   = 1'b1;
            U_IN:     c.acc_op    = ACC_IN;
            U_OUT:    c.set_show  = 1'b1;
            U_HALT:   c.set_halt  = 1'b1;
            U_JUMP:   c.pc_jump   = 1'b1;
            U_SKIPZ:  c.pc_skipz  = 1'b1;
            U_FAULT:  c.set_fault = 1'b1;
            U_PWRITE: c.prog_wr   = 1'b1;
            U_EMIT: begin
                c.out_load = 1'b1;
                c.jc       = JC_WAIT_OUT;
                c.target   = U_IDLE;
            end
            default: begin
                c.target = U_IDLE;
            end
        endcase
        return c;
    endfunction

    // Opcode dispatch table
    function automatic t_uaddr dispatch(input logic [OPC_W-1:0] opc);
        t_uaddr ua;
        case (opc)
            OP_LOAD:  ua = U_LOAD;
            OP_ADD:   ua = U_ADD;
            OP_STORE: ua = U_STORE;
            OP_SUB:   ua = U_SUB;
            OP_IN:    ua = U_IN;
            OP_OUT:   ua = U_OUT;
            OP_HALT:  ua = U_HALT;
            OP_JUMP:  ua = U_JUMP;
            OP_SKIPZ: ua = U_SKIPZ;
            default:  ua = U_FAULT;
        endcase
        return ua;
    endfunction

endpackage

FILE: design/acm_useq.sv
// Micro-program sequencer: step counter, ROM lookup and branch logic.
module acm_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  acm_pkg::t_ustat i_stat,
    output acm_pkg::t_uctl  o_ctl
);

    acm_pkg::t_uaddr r_upc;
    acm_pkg::t_uaddr n_upc;
    acm_pkg::t_uaddr upc_inc;
    acm_pkg::t_uctl  ctl;

    assign ctl     = acm_pkg::ucode(r_upc);
    assign o_ctl   = ctl;
    assign upc_inc = acm_pkg::t_uaddr'(acm_pkg::UA_W'(r_upc) + acm_pkg::UA_W'(1));

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= acm_pkg::U_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Branch select
    always_comb begin
        n_upc = upc_inc;
        case (ctl.jc)
            acm_pkg::JC_NEXT:     n_upc = upc_inc;
            acm_pkg::JC_GOTO:     n_upc = ctl.target;
            acm_pkg::JC_WAIT_CLR: n_upc = i_stat.clr_busy ? r_upc : upc_inc;
            acm_pkg::JC_WAIT_ACC: n_upc = i_stat.in_acc ? upc_inc : r_upc;
            acm_pkg::JC_IF_WRITE: n_upc = i_stat.is_write ? ctl.target : upc_inc;
            acm_pkg::JC_IF_STOP:  n_upc = i_stat.stopped ? ctl.target : upc_inc;
            acm_pkg::JC_DISPATCH: n_upc = acm_pkg::dispatch(i_stat.opcode);
            acm_pkg::JC_WAIT_OUT: n_upc = i_stat.out_busy ? r_upc : ctl.target;
            default:              n_upc = acm_pkg::U_IDLE;
        endcase
    end

endmodule

FILE: design/acm_dpath.sv
// Datapath: memories, accumulator, program counter, flags and result register.
module acm_dpath #(
    parameter int MEM_DEPTH = acm_pkg::MEM_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acm_pkg::t_uctl                    i_ctl,
    output acm_pkg::t_ustat                   o_stat,
    input  logic                              i_cmd_valid,
    input  logic                              i_action,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_addr,
    input  logic [acm_pkg::OPC_W-1:0]         i_load_opcode,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_operand,
    input  logic signed [acm_pkg::DATA_W-1:0] i_in_value,
    input  logic                              i_res_stall,
    output logic                              o_res_valid,
    output logic                              o_out_valid,
    output logic signed [acm_pkg::DATA_W-1:0] o_out_value,
    output logic [acm_pkg::FLD_W-1:0]         o_pc_value,
    output logic                              o_halted,
    output logic                              o_fault
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int XW = (AW > acm_pkg::FLD_W) ? AW : acm_pkg::FLD_W;
    localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

    // Field value modulo depth, a constant table
    logic [AW-1:0] wrap_lut [acm_pkg::ADDR_SPAN];
    for (genvar g = 0; g < acm_pkg::ADDR_SPAN; g++) begin : g_wrap
        assign wrap_lut[g] = AW'(g % MEM_DEPTH);
    end

    // Memories
    logic [acm_pkg::PWORD_W-1:0] prog_mem [MEM_DEPTH];
    logic [acm_pkg::DATA_W-1:0]  data_mem [MEM_DEPTH];

    // Latched command word
    logic                        r_action;
    logic [acm_pkg::FLD_W-1:0]   r_addr;
    logic [acm_pkg::OPC_W-1:0]   r_opc;
    logic [acm_pkg::FLD_W-1:0]   r_opd;
    logic [acm_pkg::DATA_W-1:0]  r_inval;

    logic [acm_pkg::PWORD_W-1:0] r_pword;
    logic [acm_pkg::DATA_W-1:0]  r_dword;

    // Architectural state
    logic [AW-1:0]               r_pc;
    logic [acm_pkg::DATA_W-1:0]  r_acc;
    logic                        r_halt;
    logic                        r_fault;
    logic                        r_show;

    // Clear pass
    logic [AW-1:0]               r_clr_cnt;
    logic                        r_clr_busy;

    // Result register
    logic                        r_res_valid;
    logic                        r_o_show;
    logic [acm_pkg::DATA_W-1:0]  r_o_acc;
    logic [AW-1:0]               r_o_pc;
    logic                        r_o_halt;
    logic                        r_o_fault;

    logic                        in_acc;
    logic                        out_busy;
    logic                        out_ld;
    logic [AW-1:0]               opd_addr;
    logic [AW-1:0]               pc_inc;
    logic                        dwe;
    logic [AW-1:0]               dwa;
    logic [acm_pkg::DATA_W-1:0]  dwd;
    logic [XW-1:0]               pc_ext;

    assign in_acc   = i_cmd_valid && i_ctl.in_rdy;
    assign out_busy = r_res_valid && i_res_stall;
    assign out_ld   = i_ctl.out_load && !out_busy;
    assign opd_addr = wrap_lut[r_pword[acm_pkg::FLD_W-1:0]];
    assign pc_inc   = (r_pc == LAST) ? '0 : r_pc + AW'(1);

    assign o_stat.in_acc   = in_acc;
    assign o_stat.is_write = !r_action;
    assign o_stat.stopped  = r_halt || r_fault;
    assign o_stat.clr_busy = r_clr_busy;
    assign o_stat.out_busy = out_busy;
    assign o_stat.opcode   = r_pword[acm_pkg::PWORD_W-1:acm_pkg::FLD_W];

    // Command word capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_addr   <= i_load_addr;
            r_opc    <= i_load_opcode;
            r_opd    <= i_load_operand;
            r_inval  <= i_in_value;
        end
    end

    // Program memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.prog_wr) begin
            prog_mem[wrap_lut[r_addr]] <= {r_opc, r_opd};
        end
        if (i_ctl.prog_rd) begin
            r_pword <= prog_mem[r_pc];
        end
    end

    // Data memory write port, shared with the clear pass
    assign dwe = (i_ctl.clr && r_clr_busy) || i_ctl.data_wr;
    assign dwa = i_ctl.clr ? r_clr_cnt : opd_addr;
    assign dwd = i_ctl.clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (dwe) begin
            data_mem[dwa] <= dwd;
        end
        if (i_ctl.data_rd) begin
            r_dword <= data_mem[opd_addr];
        end
    end

    // Clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (i_ctl.clr && r_clr_busy) begin
            if (r_clr_cnt == LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    // Accumulator, PC and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
            r_fault <= 1'b0;
            r_show  <= 1'b0;
        end else begin
            case (i_ctl.acc_op)
                acm_pkg::ACC_HOLD: r_acc <= r_acc;
                acm_pkg::ACC_MEM:  r_acc <= r_dword;
                acm_pkg::ACC_ADD:  r_acc <= r_acc + r_dword;
                acm_pkg::ACC_SUB:  r_acc <= r_acc - r_dword;
                acm_pkg::ACC_IN:   r_acc <= r_inval;
                default:           r_acc <= r_acc;
            endcase
            if (i_ctl.pc_inc || (i_ctl.pc_skipz && r_acc == '0)) begin
                r_pc <= pc_inc;
            end else if (i_ctl.pc_jump) begin
                r_pc <= opd_addr;
            end
            if (i_ctl.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_ctl.set_fault) begin
                r_fault <= 1'b1;
            end
            if (in_acc) begin
                r_show <= 1'b0;
            end else if (i_ctl.set_show) begin
                r_show <= 1'b1;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_ld) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_o_show  <= r_show;
            r_o_acc   <= r_acc;
            r_o_pc    <= r_pc;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
        end
    end

    assign pc_ext      = XW'(r_o_pc);
    assign o_res_valid = r_res_valid;
    assign o_out_valid = r_o_show;
    assign o_out_value = r_o_acc;
    assign o_pc_value  = pc_ext[acm_pkg::FLD_W-1:0];
    assign o_halted    = r_o_halt;
    assign o_fault     = r_o_fault;

endmodule

FILE: design/accumulator_machine_core.sv
// Accumulator machine: each word runs 4 to 6 microcode steps through the memory reads.
// A result comes back for every accepted word: a program write, a step on a stopped
// machine or an instruction.
// One word is worked on at a time; the next is taken while the result waits.
// Reset is synchronous; afterwards the data memory is zeroed, one entry a cycle,
// with the command side stalled until the clear pass is done.
module accumulator_machine_core #(
    parameter int MEM_DEPTH = acm_pkg::MEM_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_stall,
    input  logic                              i_action,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_addr,
    input  logic [acm_pkg::OPC_W-1:0]         i_load_opcode,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_operand,
    input  logic signed [acm_pkg::DATA_W-1:0] i_in_value,
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output logic                              o_out_valid,
    output logic signed [acm_pkg::DATA_W-1:0] o_out_value,
    output logic [acm_pkg::FLD_W-1:0]         o_pc_value,
    output logic                              o_halted,
    output logic                              o_fault
);

    acm_pkg::t_uctl  ctl;
    acm_pkg::t_ustat stat;

    assign o_cmd_stall = !ctl.in_rdy;

    // Sequencer
    acm_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // Datapath
    acm_dpath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_cmd_valid    (i_cmd_valid),
        .i_action       (i_action),
        .i_load_addr    (i_load_addr),
        .i_load_opcode  (i_load_opcode),
        .i_load_operand (i_load_operand),
        .i_in_value     (i_in_value),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_out_valid    (o_out_valid),
        .o_out_value    (o_out_value),
        .o_pc_value     (o_pc_value),
        .o_halted       (o_halted),
        .o_fault        (o_fault)
    );

endmodule

FILE: sim/acm_result_checker.sv
// Result checker for the accumulator machine: predicts every result word and compares it.
module acm_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  logic                              i_cmd_stall,
    input  logic                              i_action,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_addr,
    input  logic [acm_pkg::OPC_W-1:0]         i_load_opcode,
    input  logic [acm_pkg::FLD_W-1:0]         i_load_operand,
    input  logic signed [acm_pkg::DATA_W-1:0] i_in_value,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic                              i_out_valid,
    input  logic signed [acm_pkg::DATA_W-1:0] i_out_value,
    input  logic [acm_pkg::FLD_W-1:0]         i_pc_value,
    input  logic                              i_halted,
    input  logic                              i_fault,
    output int                                o_mismatches,
    output int                                o_waiting,
    output logic [acm_pkg::FLD_W-1:0]         o_pc_now
);
    import acm_pkg::*;

    // only the first few mismatches are printed, all are counted
    localparam int MAX_PRINTED = 40;

    // machine state after one word
    typedef struct packed {
        logic              shown;
        logic [DATA_W-1:0] acc;
        logic [FLD_W-1:0]  pc;
        logic              halted;
        logic              fault;
    } t_machine_state;

    // shadow copy of the machine
    logic [PWORD_W-1:0] prog_mem [MEM_DEPTH_DEF];
    logic [DATA_W-1:0]  data_mem [MEM_DEPTH_DEF];
    logic [FLD_W-1:0]   pc;
    logic [DATA_W-1:0]  acc;
    logic               halt_flag;
    logic               fault_flag;

    t_machine_state expected_states[$];
    int             mismatches = 0;
    int             results_seen = 0;

    // apply one command word to the shadow machine, return the state it reports
    function automatic t_machine_state advance_machine(
        input logic               act,
        input logic [FLD_W-1:0]   addr,
        input logic [OPC_W-1:0]   opc,
        input logic [FLD_W-1:0]   opd,
        input logic [DATA_W-1:0]  in_val
    );
        t_machine_state st;
        logic [PWORD_W-1:0] word;
        logic [FLD_W-1:0]   arg;
        st.shown = 1'b0;
        if (!act) begin
            prog_mem[addr] = {opc, opd};
        end else if (!halt_flag && !fault_flag) begin
            word = prog_mem[pc];
            arg  = word[FLD_W-1:0];
            // fetch advances the PC before the opcode acts, halt and fault too
            pc = pc + 1'b1;
            case (word[PWORD_W-1:FLD_W])
                OP_LOAD:  acc = data_mem[arg];
                OP_ADD:   acc = acc + data_mem[arg];
                OP_STORE: data_mem[arg] = acc;
                OP_SUB:   acc = acc - data_mem[arg];
                OP_IN:    acc = in_val;
                OP_OUT:   st.shown = 1'b1;
                OP_HALT:  halt_flag = 1'b1;
                OP_JUMP:  pc = arg;
                OP_SKIPZ: begin
                    if (acc == '0) pc = pc + 1'b1;
                end
                default:  fault_flag = 1'b1;
            endcase
        end
        st.acc    = acc;
        st.pc     = pc;
        st.halted = halt_flag;
        st.fault  = fault_flag;
        return st;
    endfunction

    task automatic report_mismatch(
        input string             what,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        if (mismatches < MAX_PRINTED)
            $display("%0t: result word %0d: %s is %0h, predicted %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // watch both channels; results are checked before a new command is predicted
    always @(posedge i_clk) begin
        t_machine_state want;
        if (!i_rst_n) begin
            for (int k = 0; k < MEM_DEPTH_DEF; k++) begin
                prog_mem[k] = '0;
                data_mem[k] = '0;
            end
            pc         = '0;
            acc        = '0;
            halt_flag  = 1'b0;
            fault_flag = 1'b0;
            expected_states.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("unexpected word", i_out_value, '0);
                end else begin
                    want = expected_states.pop_front();
                    if (i_out_valid !== want.shown)
                        report_mismatch("out_valid", DATA_W'(i_out_valid),
                                        DATA_W'(want.shown));
                    if (i_out_value !== want.acc)
                        report_mismatch("out_value", i_out_value, want.acc);
                    if (i_pc_value !== want.pc)
                        report_mismatch("pc_value", DATA_W'(i_pc_value), DATA_W'(want.pc));
                    if (i_halted !== want.halted)
                        report_mismatch("halted", DATA_W'(i_halted), DATA_W'(want.halted));
                    if (i_fault !== want.fault)
                        report_mismatch("fault", DATA_W'(i_fault), DATA_W'(want.fault));
                end
                results_seen++;
            end
            if (i_cmd_valid && !i_cmd_stall)
                expected_states.push_back(advance_machine(i_action, i_load_addr,
                    i_load_opcode, i_load_operand, i_in_value));
        end
        o_mismatches <= mismatches;
        o_waiting    <= expected_states.size();
        o_pc_now     <= pc;
    end

endmodule

FILE: sim/accumulator_machine_core_tb.sv
// Testbench top for the accumulator machine: stimulus, handshake idling and the verdict.
module accumulator_machine_core_tb;
    import acm_pkg::*;

    localparam logic             ACT_WRITE      = 1'b0;
    localparam logic             ACT_EXEC       = 1'b1;
    localparam logic [OPC_W-1:0] OPC_BAD_LOW    = 4'd0;
    localparam logic [OPC_W-1:0] OPC_BAD_HIGH   = 4'd15;
    localparam logic [FLD_W-1:0] FIELD_MAX      = 7'd127;
    localparam int               RANDOM_WORDS   = 1550;
    localparam int               CALM_WORDS     = 250;
    localparam int               SEGMENT        = 80;
    localparam int               TAIL_WORDS     = 24;
    localparam int               SETTLE_CYCLES  = 16;
    localparam int               WATCHDOG_LIMIT = 3000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cmd_valid;
    logic                     cmd_action;
    logic [FLD_W-1:0]         cmd_addr;
    logic [OPC_W-1:0]         cmd_opcode;
    logic [FLD_W-1:0]         cmd_operand;
    logic signed [DATA_W-1:0] cmd_value;
    logic                     res_stall;
    logic                     o_cmd_stall;
    logic                     o_res_valid;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_out_value;
    logic [FLD_W-1:0]         o_pc_value;
    logic                     o_halted;
    logic                     o_fault;
    int                       chk_mismatches;
    int                       chk_waiting;
    logic [FLD_W-1:0]         chk_pc_now;

    // idling switches, changed per segment of the random part
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int quiet_cycles = 0;

    accumulator_machine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_stall    (o_cmd_stall),
        .i_action       (cmd_action),
        .i_load_addr    (cmd_addr),
        .i_load_opcode  (cmd_opcode),
        .i_load_operand (cmd_operand),
        .i_in_value     (cmd_value),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (res_stall),
        .o_out_valid    (o_out_valid),
        .o_out_value    (o_out_value),
        .o_pc_value     (o_pc_value),
        .o_halted       (o_halted),
        .o_fault        (o_fault)
    );

    acm_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd_stall    (o_cmd_stall),
        .i_action       (cmd_action),
        .i_load_addr    (cmd_addr),
        .i_load_opcode  (cmd_opcode),
        .i_load_operand (cmd_operand),
        .i_in_value     (cmd_value),
        .i_res_valid    (o_res_valid),
        .i_res_stall    (res_stall),
        .i_out_valid    (o_out_valid),
        .i_out_value    (o_out_value),
        .i_pc_value     (o_pc_value),
        .i_halted       (o_halted),
        .i_fault        (o_fault),
        .o_mismatches   (chk_mismatches),
        .o_waiting      (chk_waiting),
        .o_pc_now       (chk_pc_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // opcodes that keep the machine running
    function automatic logic [OPC_W-1:0] pick_run_opcode();
        case ($urandom_range(0, 7))
            0:       return OP_LOAD;
            1:       return OP_ADD;
            2:       return OP_STORE;
            3:       return OP_SUB;
            4:       return OP_IN;
            5:       return OP_OUT;
            6:       return OP_JUMP;
            default: return OP_SKIPZ;
        endcase
    endfunction

    // invalid opcodes: zero and everything above skip-if-zero
    function automatic logic [OPC_W-1:0] pick_bad_opcode();
        int r;
        r = $urandom_range(0, OPC_BAD_HIGH - OP_SKIPZ);
        if (r == 0) return OPC_BAD_LOW;
        return OPC_W'(OP_SKIPZ + r);
    endfunction

    function automatic logic [FLD_W-1:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FIELD_MAX;
            default: return FLD_W'($urandom_range(0, FIELD_MAX));
        endcase
    endfunction

    // zero often, so skip-if-zero takes both branches
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // offer one command word, optionally after an idle burst, and wait for it to go in
    task automatic send_word(
        input logic              act,
        input logic [FLD_W-1:0]  addr,
        input logic [OPC_W-1:0]  opc,
        input logic [FLD_W-1:0]  opd,
        input logic [DATA_W-1:0] val
    );
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            cmd_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge i_clk);
        end
        cmd_valid   <= 1'b1;
        cmd_action  <= act;
        cmd_addr    <= addr;
        cmd_opcode  <= opc;
        cmd_operand <= opd;
        cmd_value   <= val;
        @(posedge i_clk);
        while (o_cmd_stall) @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_waiting != 0) @(posedge i_clk);
    endtask

    // result side stalls in random bursts
    initial begin
        int burst;
        res_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                res_stall <= 1'b1;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge i_clk);
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((cmd_valid && !o_cmd_stall) || (o_res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int               k;
        int               pick;
        logic [FLD_W-1:0] addr;
        logic [FLD_W-1:0] stop_pc;
        logic [OPC_W-1:0] stop_opc;

        i_rst_n     = 1'b0;
        cmd_valid   = 1'b0;
        cmd_action  = ACT_WRITE;
        cmd_addr    = '0;
        cmd_opcode  = OPC_BAD_LOW;
        cmd_operand = '0;
        cmd_value   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole program store so no fetch ever hits an unwritten word
        for (k = 0; k < MEM_DEPTH_DEF; k++)
            send_word(ACT_WRITE, FLD_W'(k), pick_run_opcode(), pick_field(), pick_value());

        // directed program at the start address: wrap of add and subtract,
        // output, skip taken, jump to the last address and PC wrap through a skip
        send_word(ACT_WRITE, 7'd0,      OP_IN,    '0,        '0);
        send_word(ACT_WRITE, 7'd1,      OP_STORE, FIELD_MAX, '0);
        send_word(ACT_WRITE, 7'd2,      OP_ADD,   FIELD_MAX, '0);
        send_word(ACT_WRITE, 7'd3,      OP_OUT,   '0,        '0);
        send_word(ACT_WRITE, 7'd4,      OP_IN,    '0,        '0);
        send_word(ACT_WRITE, 7'd5,      OP_SUB,   FIELD_MAX, '0);
        send_word(ACT_WRITE, 7'd6,      OP_LOAD,  '0,        '0);
        send_word(ACT_WRITE, 7'd7,      OP_SKIPZ, '0,        '0);
        send_word(ACT_WRITE, 7'd8,      OP_JUMP,  '0,        '0);
        send_word(ACT_WRITE, 7'd9,      OP_JUMP,  FIELD_MAX, '0);
        send_word(ACT_WRITE, FIELD_MAX, OP_SKIPZ, '0,        '0);
        send_word(ACT_EXEC, '0, '0, '0, 32'h7FFF_FFFF);
        send_word(ACT_EXEC, '0, '0, '0, pick_value());
        send_word(ACT_EXEC, '0, '0, '0, pick_value());
        send_word(ACT_EXEC, '0, '0, '0, pick_value());
        send_word(ACT_EXEC, '0, '0, '0, 32'h8000_0000);
        for (k = 0; k < 5; k++)
            send_word(ACT_EXEC, pick_field(), pick_run_opcode(), pick_field(), pick_value());

        // random part: mostly execution, some program rewrites, a few broken rewrites
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % SEGMENT == 0) begin
                gaps_on  = (k < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
                stall_on = (k < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 39);
            addr = FLD_W'($urandom_range(0, FIELD_MAX));
            if (pick == 0) begin
                // an invalid word lands and is replaced before it can be fetched
                send_word(ACT_WRITE, addr, pick_bad_opcode(), pick_field(), pick_value());
                send_word(ACT_WRITE, addr, pick_run_opcode(), pick_field(), pick_value());
            end else if (pick < 8) begin
                send_word(ACT_WRITE, addr, pick_run_opcode(), pick_field(), pick_value());
            end else begin
                send_word(ACT_EXEC, addr, OPC_W'($urandom_range(0, OPC_BAD_HIGH)),
                          pick_field(), pick_value());
            end
        end

        // stop the machine at its current PC, by halt or by an invalid opcode
        wait_drained();
        stop_pc  = chk_pc_now;
        stop_opc = ($urandom_range(0, 1) == 0) ? OP_HALT : pick_bad_opcode();
        send_word(ACT_WRITE, stop_pc, stop_opc, pick_field(), pick_value());
        send_word(ACT_EXEC, '0, '0, '0, pick_value());

        // stopped machine: steps change nothing, writes still land
        for (k = 0; k < TAIL_WORDS; k++) begin
            if (k % 3 == 0)
                send_word(ACT_EXEC, pick_field(), OPC_W'($urandom_range(0, OPC_BAD_HIGH)),
                          pick_field(), pick_value());
            else if (k == 1)
                send_word(ACT_WRITE, '0, OPC_BAD_LOW, '0, '0);
            else if (k == 2)
                send_word(ACT_WRITE, FIELD_MAX, OPC_BAD_HIGH, FIELD_MAX, 32'hFFFF_FFFF);
            else
                send_word(ACT_WRITE, pick_field(), OPC_W'($urandom_range(0, OPC_BAD_HIGH)),
                          pick_field(), pick_value());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (chk_mismatches == 0 && chk_waiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
